// ===== rtl/cosf_pkg.sv =====
// cosf_pkg: shared constants for the cascaded one-pole shaping filter
// register map of the configuration port; no dependencies
package cosf_pkg;

  // configuration register index width and register map
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_MAIN_COEFF   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SMOOTH_COEFF = 2'd1;

endpackage

// ===== rtl/cosf_sample_if.sv =====
// cosf_sample_if: request channel carrying one signed audio sample
// valid/ready handshake; no dependencies
interface cosf_sample_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// ===== rtl/cosf_result_if.sv =====
// cosf_result_if: request channel carrying the shaped and smoothed sample
// valid/ready handshake; no dependencies
interface cosf_result_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] shaped;
  logic signed [SAMPLE_BITS-1:0] smoothed;

  modport source (output valid, output shaped, output smoothed, input ready);
  modport sink   (input valid, input shaped, input smoothed, output ready);
endinterface

// ===== rtl/cosf_lowpass.sv =====
// cosf_lowpass: one-pole lowpass state with a bit-serial coefficient multiply
// one coefficient bit per cycle, shift-add; no package dependencies
module cosf_lowpass #(
  parameter int STATE_BITS = 40,
  parameter int COEFF_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [STATE_BITS-1:0] target,
  input  logic        [COEFF_BITS-1:0] coeff,
  output logic signed [STATE_BITS-1:0] state,
  output logic                         done
);
  localparam int CNT_BITS = $clog2(COEFF_BITS);

  logic signed [STATE_BITS:0]   diff;
  logic signed [STATE_BITS:0]   prod;
  logic        [COEFF_BITS-1:0] coeff_sr;
  logic        [CNT_BITS-1:0]   cnt;
  logic                         busy;
  logic                         update;
  logic signed [STATE_BITS-1:0] z;
  logic signed [STATE_BITS+1:0] sum;

  // partial product plus difference when the current coefficient bit is set
  assign sum = {prod[STATE_BITS], prod} + (coeff_sr[0] ? {diff[STATE_BITS], diff} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      update <= 1'b0;
      z      <= '0;
    end else begin
      update <= 1'b0;
      if (start) begin
        diff     <= {target[STATE_BITS-1], target} - {z[STATE_BITS-1], z};
        coeff_sr <= coeff;
        prod     <= '0;
        cnt      <= '0;
        busy     <= 1'b1;
      end else if (busy) begin
        // low product bits drop out, leaving floor(coeff * diff / 2^COEFF_BITS)
        prod     <= sum[STATE_BITS+1:1];
        coeff_sr <= coeff_sr >> 1;
        cnt      <= cnt + 1'b1;
        if (cnt == CNT_BITS'(COEFF_BITS - 1)) begin
          busy   <= 1'b0;
          update <= 1'b1;
        end
      end
      if (update) begin
        z <= z + prod[STATE_BITS-1:0];
      end
    end
  end

  assign state = z;
  assign done  = update;
endmodule

// ===== rtl/cascaded_one_pole_shaping_filter_core.sv =====
// cascaded_one_pole_shaping_filter_core: top level of the shaping filter
// uses cosf_pkg, cosf_sample_if, cosf_result_if and cosf_lowpass
//
// usage
//   sample_in carries one signed sample per request; result_out returns one
//   request per sample with the shaped sample and the smoothed level
//   cfg_write/cfg_index/cfg_data set main_coeff (index 0) and smooth_coeff
//   (index 1); other indexes are ignored, write only while idle
// timing
//   one sample in flight at a time; ready is high only while idle
//   the wait from accept to result_out.valid is set mostly by the bit-serial
//   coefficient multiply in each lowpass, one coefficient bit per cycle
//   the three shaping lowpasses run side by side, the smoother runs after
//   the shaping sum is formed in ST_SUM_A and ST_SUM_B and clamped in ST_SAT
// reset
//   rst clears all four lowpass states, both coefficients and the
//   output valid flag
// stall
//   a finished result sits in the output register until taken; the next
//   sample is accepted meanwhile and only the final load waits
module cascaded_one_pole_shaping_filter_core
  import cosf_pkg::*;
#(
  parameter int SAMPLE_BITS = 24,
  parameter int COEFF_BITS  = 16,
  parameter int GUARD_BITS  = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  cosf_sample_if.sink               sample_in,
  cosf_result_if.source             result_out,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [COEFF_BITS-1:0]     cfg_data
);
  localparam int STATE_BITS = SAMPLE_BITS + GUARD_BITS;
  localparam int ACC_BITS   = STATE_BITS + 2;

  // saturation bounds of the shaped value at guard precision
  localparam logic signed [ACC_BITS-1:0] SAT_HI =
    {{3{1'b0}}, {(SAMPLE_BITS-1){1'b1}}, {GUARD_BITS{1'b0}}};
  localparam logic signed [ACC_BITS-1:0] SAT_LO =
    {{3{1'b1}}, {(SAMPLE_BITS-1){1'b0}}, {GUARD_BITS{1'b0}}};
  localparam logic [STATE_BITS:0] HALF = (STATE_BITS+1)'(1) << (GUARD_BITS - 1);

  // sequencer codes
  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_SHAPE_LP  = 3'd1;
  localparam logic [2:0] ST_SUM_A     = 3'd2;
  localparam logic [2:0] ST_SUM_B     = 3'd3;
  localparam logic [2:0] ST_SAT       = 3'd4;
  localparam logic [2:0] ST_SMOOTH_GO = 3'd5;
  localparam logic [2:0] ST_SMOOTH_LP = 3'd6;
  localparam logic [2:0] ST_DONE      = 3'd7;

  logic [2:0]                   state;
  logic [COEFF_BITS-1:0]        main_coeff;
  logic [COEFF_BITS-1:0]        smooth_coeff;
  logic signed [SAMPLE_BITS-1:0] sample_reg;
  logic signed [ACC_BITS-1:0]   acc;
  logic                         out_valid;
  logic signed [SAMPLE_BITS-1:0] shaped;
  logic signed [SAMPLE_BITS-1:0] smoothed;

  logic                         accept;
  logic                         smooth_start;
  logic signed [STATE_BITS-1:0] sample_scaled;
  logic signed [STATE_BITS-1:0] fast_state;
  logic signed [STATE_BITS-1:0] middle_state;
  logic signed [STATE_BITS-1:0] slow_state;
  logic signed [STATE_BITS-1:0] smooth_state;
  logic                         fast_done;
  logic                         middle_done;
  logic                         slow_done;
  logic                         smooth_done;
  logic signed [ACC_BITS-1:0]   xs_ext;
  logic signed [ACC_BITS-1:0]   half_fast;
  logic signed [ACC_BITS-1:0]   quarter_middle;
  logic signed [ACC_BITS-1:0]   eighth_slow;
  logic                         out_load;

  // round to nearest (ties up) back to sample units, then clamp
  function automatic logic [SAMPLE_BITS-1:0] to_sample(input logic [STATE_BITS-1:0] v);
    logic [STATE_BITS:0]  t;
    logic [SAMPLE_BITS:0] r;
    t = {v[STATE_BITS-1], v} + HALF;
    r = t[STATE_BITS:GUARD_BITS];
    if (r[SAMPLE_BITS] != r[SAMPLE_BITS-1]) begin
      to_sample = r[SAMPLE_BITS] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                 : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end else begin
      to_sample = r[SAMPLE_BITS-1:0];
    end
  endfunction

  assign accept           = sample_in.valid && sample_in.ready;
  assign sample_in.ready  = (state == ST_IDLE);
  assign smooth_start     = (state == ST_SMOOTH_GO);
  assign sample_scaled    = {sample_in.sample, {GUARD_BITS{1'b0}}};
  assign out_load         = (state == ST_DONE) && (!out_valid || result_out.ready);

  assign result_out.valid    = out_valid;
  assign result_out.shaped   = shaped;
  assign result_out.smoothed = smoothed;

  // shaping terms at guard precision, floor shifts of the states
  assign xs_ext         = {{2{sample_reg[SAMPLE_BITS-1]}}, sample_reg, {GUARD_BITS{1'b0}}};
  assign half_fast      = {{3{fast_state[STATE_BITS-1]}}, fast_state[STATE_BITS-1:1]};
  assign quarter_middle = {{4{middle_state[STATE_BITS-1]}}, middle_state[STATE_BITS-1:2]};
  assign eighth_slow    = {{5{slow_state[STATE_BITS-1]}}, slow_state[STATE_BITS-1:3]};

  // fast, middle and slow lowpasses run together on the new sample
  cosf_lowpass #(.STATE_BITS(STATE_BITS), .COEFF_BITS(COEFF_BITS)) u_fast (
    .clk(clk), .rst(rst), .start(accept), .target(sample_scaled),
    .coeff(main_coeff), .state(fast_state), .done(fast_done)
  );

  cosf_lowpass #(.STATE_BITS(STATE_BITS), .COEFF_BITS(COEFF_BITS)) u_middle (
    .clk(clk), .rst(rst), .start(accept), .target(sample_scaled),
    .coeff(main_coeff >> 2), .state(middle_state), .done(middle_done)
  );

  cosf_lowpass #(.STATE_BITS(STATE_BITS), .COEFF_BITS(COEFF_BITS)) u_slow (
    .clk(clk), .rst(rst), .start(accept), .target(sample_scaled),
    .coeff(main_coeff >> 4), .state(slow_state), .done(slow_done)
  );

  // output smoother follows the saturated shaped value
  cosf_lowpass #(.STATE_BITS(STATE_BITS), .COEFF_BITS(COEFF_BITS)) u_smooth (
    .clk(clk), .rst(rst), .start(smooth_start), .target(acc[STATE_BITS-1:0]),
    .coeff(smooth_coeff), .state(smooth_state), .done(smooth_done)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      main_coeff   <= '0;
      smooth_coeff <= '0;
    end else if (cfg_write) begin
      if (cfg_index == REG_MAIN_COEFF) begin
        main_coeff <= cfg_data;
      end else if (cfg_index == REG_SMOOTH_COEFF) begin
        smooth_coeff <= cfg_data;
      end
    end
  end

  // sequencer and shaping accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            sample_reg <= sample_in.sample;
            state      <= ST_SHAPE_LP;
          end
        end
        ST_SHAPE_LP: begin
          // all three finish on the same cycle
          if (fast_done && middle_done && slow_done) begin
            state <= ST_SUM_A;
          end
        end
        ST_SUM_A: begin
          acc   <= xs_ext - half_fast - quarter_middle;
          state <= ST_SUM_B;
        end
        ST_SUM_B: begin
          acc   <= acc - eighth_slow;
          state <= ST_SAT;
        end
        ST_SAT: begin
          if (acc > SAT_HI) begin
            acc <= SAT_HI;
          end else if (acc < SAT_LO) begin
            acc <= SAT_LO;
          end
          state <= ST_SMOOTH_GO;
        end
        ST_SMOOTH_GO: begin
          state <= ST_SMOOTH_LP;
        end
        ST_SMOOTH_LP: begin
          if (smooth_done) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          // wait for the output register to free up
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
        shaped    <= to_sample(acc[STATE_BITS-1:0]);
        smoothed  <= to_sample(smooth_state);
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule

// ===== rtl/cosf_checker.sv =====
// cosf_checker: port-level assertions for the shaping filter core
// bound to cascaded_one_pole_shaping_filter_core; no package dependencies
module cosf_checker #(
  parameter int SAMPLE_BITS = 24
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SAMPLE_BITS-1:0] out_shaped,
  input logic [SAMPLE_BITS-1:0] out_smoothed
);
  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_shaped) && $stable(out_smoothed))
    else $error("stalled result changed or dropped");

  // one sample in flight: ready drops right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second sample taken while busy");

  // the serial multiply means no result can appear right after an accept
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared one cycle after accept");

  // reset empties the output register
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");
endmodule

bind cascaded_one_pole_shaping_filter_core cosf_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_cosf_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (sample_in.valid),
  .in_ready     (sample_in.ready),
  .out_valid    (result_out.valid),
  .out_ready    (result_out.ready),
  .out_shaped   (result_out.shaped),
  .out_smoothed (result_out.smoothed)
);
